/* design/dqa_pkg.sv */
// Shared constants, widths and types for the destination queue assigner.
// No dependencies; destination_queue_assigner and dqa_scan import this package.
package dqa_pkg;

	localparam int MAX_QUEUES = 16;
	localparam int IDX_W      = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
	localparam int CNT_W      = $clog2(MAX_QUEUES + 1);
	localparam int ADDR_W     = 32;
	localparam int NQ_W       = 5;
	localparam int QI_W       = 4;
	localparam int DROP_W     = 32;

	localparam logic [NQ_W-1:0]   NQ_RESET = 5'd16;
	localparam logic [DROP_W-1:0] DROP_MAX = '1;

	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_FREE   = 1'b1;

	// Outcome of one table scan
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic             idle_fnd;
		logic [IDX_W-1:0] idle_idx;
	} scan_res_t;

endpackage

/* design/destination_queue_assigner.sv */
// Destination queue assigner: maps packet destinations to burst queues.
// Depends on dqa_pkg, dqa_ram and dqa_scan.
//
// Input channel (in_valid/in_stall, op, dest_address): op 0 dispatches a
// packet, op 1 frees the queue that holds dest_address and gives no result.
// Output channel (out_valid/out_stall): one result per packet, carrying
// queue_index, dropped and the running drop_total.
// Configuration: wr_en/wr_data write num_queues; write it only while idle.
//
// One request is processed at a time. Each request scans the table entries
// up to and including the first match, else all entries in use (at most
// 16), with one destination RAM read and one 32-bit compare per entry.
// A finished result sits in the output register; a stalled receiver holds
// it there and the block stops accepting once a second result is waiting.
// Reset empties the table, clears all busy marks and the drop counter, and
// sets num_queues to 16; no clearing pass is needed.
module destination_queue_assigner import dqa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [NQ_W-1:0]   wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	input  logic [ADDR_W-1:0] dest_address,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [QI_W-1:0]   queue_index,
	output logic              dropped,
	output logic [DROP_W-1:0] drop_total
);

	typedef enum logic [1:0] {T_IDLE, T_SCAN, T_OUT} state_t;

	state_t              st_q;
	logic [NQ_W-1:0]     nq_q;
	logic [MAX_QUEUES-1:0] busy_q;
	logic [CNT_W-1:0]    count_q;
	logic [DROP_W-1:0]   drop_cnt_q;
	logic                op_q;
	logic [ADDR_W-1:0]   dest_q;
	logic [QI_W-1:0]     pend_idx_q;
	logic                pend_drop_q;
	logic [DROP_W-1:0]   pend_total_q;
	logic                out_valid_q;
	logic [QI_W-1:0]     qi_q;
	logic                dropped_q;
	logic [DROP_W-1:0]   total_q;

	logic                in_accept;
	logic                out_take;
	logic                out_free;
	logic                room;
	logic                scan_done;
	scan_res_t           sres;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic [ADDR_W-1:0]   rd_data;
	logic                ram_we;
	logic                append;
	logic                set_en;
	logic [IDX_W-1:0]    set_pos;
	logic                drop_now;
	logic [DROP_W-1:0]   drop_next;

	assign in_stall  = (st_q != T_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign queue_index = qi_q;
	assign dropped     = dropped_q;
	assign drop_total  = total_q;

	// table may grow while under both the programmed limit and its depth
	assign room = (32'(count_q) < 32'(nq_q)) && (count_q != CNT_W'(MAX_QUEUES));

	always_comb begin
		ram_we   = 1'b0;
		append   = 1'b0;
		set_en   = 1'b0;
		set_pos  = '0;
		drop_now = 1'b0;
		if ((st_q == T_SCAN) && scan_done && (op_q == OP_PACKET)) begin
			if (sres.hit) begin
				set_en  = 1'b1;
				set_pos = sres.hit_idx;
			end else if (room) begin
				set_en  = 1'b1;
				set_pos = IDX_W'(count_q);
				ram_we  = 1'b1;
				append  = 1'b1;
			end else if (sres.idle_fnd) begin
				set_en  = 1'b1;
				set_pos = sres.idle_idx;
				ram_we  = 1'b1;
			end else begin
				drop_now = 1'b1;
			end
		end
		drop_next = (drop_now && (drop_cnt_q != DROP_MAX)) ? drop_cnt_q + DROP_W'(1)
			: drop_cnt_q;
	end

	dqa_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (MAX_QUEUES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (set_pos),
		.wdata (dest_q),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	dqa_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_accept),
		.dest    (dest_address),
		.count   (count_q),
		.busy    (busy_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.done    (scan_done),
		.res     (sres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= T_IDLE;
			nq_q        <= NQ_RESET;
			busy_q      <= '0;
			count_q     <= '0;
			drop_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				nq_q <= wr_data;
			end
			if ((st_q == T_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				T_IDLE: begin
					if (in_accept) begin
						op_q   <= op;
						dest_q <= dest_address;
						st_q   <= T_SCAN;
					end
				end
				T_SCAN: begin
					if (scan_done) begin
						if (op_q == OP_FREE) begin
							if (sres.hit) begin
								busy_q[sres.hit_idx] <= 1'b0;
							end
							st_q <= T_IDLE;
						end else begin
							if (set_en) begin
								busy_q[set_pos] <= 1'b1;
							end
							if (append) begin
								count_q <= count_q + CNT_W'(1);
							end
							drop_cnt_q   <= drop_next;
							pend_idx_q   <= set_en ? QI_W'(set_pos) : '0;
							pend_drop_q  <= drop_now;
							pend_total_q <= drop_next;
							st_q         <= T_OUT;
						end
					end
				end
				T_OUT: begin
					// hold the result until the output register is free
					if (out_free) begin
						qi_q      <= pend_idx_q;
						dropped_q <= pend_drop_q;
						total_q   <= pend_total_q;
						st_q      <= T_IDLE;
					end
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> (st_q == T_SCAN))
		else $error("scan finished outside of a scan");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_QUEUES))
		else $error("entry count exceeds table depth");

	a_drop_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (drop_cnt_q >= $past(drop_cnt_q)))
		else $error("drop counter decreased");

	a_write_not_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (scan_done && !sres.hit && (op_q == OP_PACKET)))
		else $error("table written without a packet miss");

endmodule

/* design/dqa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dqa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/dqa_scan.sv */
// Table scan sequencer: walks the destination RAM one entry a cycle through
// a single comparator. Depends on dqa_pkg.
module dqa_scan import dqa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [ADDR_W-1:0]     dest,
	input  logic [CNT_W-1:0]      count,
	input  logic [MAX_QUEUES-1:0] busy,
	output logic                  rd_en,
	output logic [IDX_W-1:0]      rd_addr,
	input  logic [ADDR_W-1:0]     rd_data,
	output logic                  done,
	output scan_res_t             res
);

	typedef enum logic {S_IDLE, S_SCAN} state_t;

	state_t           st_q;
	logic [ADDR_W-1:0] dest_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic             done_q;
	scan_res_t        res_q;

	logic             hit_now;
	logic             finish;
	logic             issue;
	logic [IDX_W-1:0] issue_addr;

	assign hit_now = cmp_vld_s1 && (rd_data == dest_q);
	assign finish  = (st_q == S_SCAN) && cmp_vld_s1 && (hit_now || (rd_idx_q == count));

	always_comb begin
		case (st_q)
			S_IDLE:  issue = start && (count != '0);
			S_SCAN:  issue = !hit_now && (rd_idx_q < count);
			default: issue = 1'b0;
		endcase
		issue_addr = (st_q == S_IDLE) ? '0 : rd_idx_q[IDX_W-1:0];
	end

	assign rd_en   = issue;
	assign rd_addr = issue_addr;
	assign done    = done_q;
	assign res     = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			cmp_vld_s1 <= 1'b0;
			done_q     <= 1'b0;
			res_q      <= '0;
		end else begin
			done_q     <= ((st_q == S_IDLE) && start && (count == '0)) || finish;
			cmp_vld_s1 <= issue;
			cmp_idx_s1 <= issue_addr;
			case (st_q)
				S_IDLE: begin
					if (start) begin
						dest_q   <= dest;
						res_q    <= '0;
						rd_idx_q <= CNT_W'(1);
						// empty table: nothing to read
						if (count != '0) begin
							st_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					// remember the first idle entry passed before any match
					if (cmp_vld_s1 && !hit_now && !busy[cmp_idx_s1] && !res_q.idle_fnd) begin
						res_q.idle_fnd <= 1'b1;
						res_q.idle_idx <= cmp_idx_s1;
					end
					if (finish) begin
						res_q.hit     <= hit_now;
						res_q.hit_idx <= cmp_idx_s1;
						st_q          <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* sim/tb_destination_queue_assigner.sv */
// Self-checking testbench for destination_queue_assigner: a queued driver and a
// monitor check each packet's queue choice against a predictor of the table.
// Depends on dqa_pkg and the design files under design/.
module tb_destination_queue_assigner import dqa_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYC  = 32;
	localparam int LONG_HOLD  = 400;
	localparam int HOLD_AFTER = 150;

	typedef enum {STEP_REQ, STEP_CFG, STEP_DRAIN} step_kind_t;

	typedef struct {
		step_kind_t        kind;
		logic              op_code;
		logic [ADDR_W-1:0] addr;
		logic [NQ_W-1:0]   nq_val;
		int                gap;
	} plan_step_t;

	typedef struct packed {
		logic [QI_W-1:0]   qi;
		logic              drp;
		logic [DROP_W-1:0] tot;
	} grant_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              wr_en = 1'b0;
	logic [NQ_W-1:0]   wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              op = OP_PACKET;
	logic [ADDR_W-1:0] dest_address = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [QI_W-1:0]   queue_index;
	logic              dropped;
	logic [DROP_W-1:0] drop_total;

	destination_queue_assigner u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.dest_address (dest_address),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.queue_index  (queue_index),
		.dropped      (dropped),
		.drop_total   (drop_total)
	);

	// Predicted table state
	logic [ADDR_W-1:0] tbl_dest [MAX_QUEUES];
	logic              tbl_busy [MAX_QUEUES];
	int                tbl_used = 0;
	logic [DROP_W-1:0] drops = '0;
	logic [NQ_W-1:0]   limit_cfg = NQ_RESET;

	plan_step_t req_plan [$];
	grant_t     expected_grants [$];

	int err_cnt = 0;
	int got_cnt = 0;
	int gap_cnt = 0;
	int quiet_cnt = 0;
	int hold_left = 0;
	bit stalling = 1'b0;
	bit long_hold_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < MAX_QUEUES; i++)
			tbl_busy[i] = 1'b0;
	end

	// Predict the grant for one accepted request; a free gives none.
	function automatic void assign_queue(input logic opv, input logic [ADDR_W-1:0] dst);
		int hit;
		int idle;
		int lim;
		int i;
		grant_t g;
		hit = -1;
		idle = -1;
		i = 0;
		while (hit < 0 && i < tbl_used) begin
			if (tbl_dest[i] == dst)
				hit = i;
			else if (idle < 0 && !tbl_busy[i])
				idle = i;
			i++;
		end
		if (opv == OP_FREE) begin
			if (hit >= 0)
				tbl_busy[hit] = 1'b0;
			return;
		end
		lim = (int'(limit_cfg) > MAX_QUEUES) ? MAX_QUEUES : int'(limit_cfg);
		if (hit < 0) begin
			if (tbl_used < lim) begin
				hit = tbl_used;
				tbl_dest[hit] = dst;
				tbl_used++;
			end else if (idle >= 0) begin
				hit = idle;
				tbl_dest[hit] = dst;
			end
		end
		if (hit >= 0) begin
			tbl_busy[hit] = 1'b1;
			g.qi = QI_W'(hit);
			g.drp = 1'b0;
		end else begin
			if (drops != DROP_MAX)
				drops = drops + 1'b1;
			g.qi = '0;
			g.drp = 1'b1;
		end
		g.tot = drops;
		expected_grants = {expected_grants, g};
	endfunction

	// Mostly short waits, a few long ones
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 1) == 0)
			return 0;
		return pick_len();
	endfunction

	task automatic add_req(input logic opv, input logic [ADDR_W-1:0] a, input int g);
		plan_step_t s;
		s.kind = STEP_REQ;
		s.op_code = opv;
		s.addr = a;
		s.nq_val = '0;
		s.gap = g;
		req_plan = {req_plan, s};
	endtask

	// Drain the block, then write num_queues
	task automatic add_cfg(input logic [NQ_W-1:0] v);
		plan_step_t s;
		s.kind = STEP_DRAIN;
		s.op_code = OP_PACKET;
		s.addr = '0;
		s.nq_val = '0;
		s.gap = 0;
		req_plan = {req_plan, s};
		s.kind = STEP_CFG;
		s.nq_val = v;
		req_plan = {req_plan, s};
	endtask

	// Driver
	always @(posedge clk) begin
		logic nv;
		logic nw;
		if (arst_n) begin
			nv = in_valid;
			nw = 1'b0;
			if (in_valid && !in_stall) begin
				assign_queue(op, dest_address);
				nv = 1'b0;
			end
			if (!nv && req_plan.size() > 0) begin
				case (req_plan[0].kind)
					STEP_REQ: begin
						if (gap_cnt < req_plan[0].gap) begin
							gap_cnt++;
						end else begin
							gap_cnt = 0;
							nv = 1'b1;
							op <= req_plan[0].op_code;
							dest_address <= req_plan[0].addr;
							void'(req_plan.pop_front());
						end
					end
					STEP_DRAIN: begin
						// hold until nothing is in flight, frees included
						if (expected_grants.size() == 0 && !in_valid)
							quiet_cnt++;
						else
							quiet_cnt = 0;
						if (quiet_cnt >= DRAIN_CYC) begin
							quiet_cnt = 0;
							void'(req_plan.pop_front());
						end
					end
					STEP_CFG: begin
						nw = 1'b1;
						wr_data <= req_plan[0].nq_val;
						limit_cfg = req_plan[0].nq_val;
						void'(req_plan.pop_front());
					end
					default: void'(req_plan.pop_front());
				endcase
			end
			in_valid <= nv;
			wr_en <= nw;
		end
	end

	// Monitor and receiver stall
	always @(posedge clk) begin
		grant_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got_cnt++;
				if (expected_grants.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("%0t: unexpected grant qi=%0d dropped=%0b total=%0d",
							$realtime, queue_index, dropped, drop_total);
				end else begin
					want = expected_grants.pop_front();
					if (want.qi !== queue_index || want.drp !== dropped ||
							want.tot !== drop_total) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("%0t: mismatch exp %0d/%0b/%0d got %0d/%0b/%0d",
								$realtime, want.qi, want.drp, want.tot,
								queue_index, dropped, drop_total);
					end
				end
			end
			if (!long_hold_done && got_cnt >= HOLD_AFTER) begin
				// one long back-pressure stretch to fill the block
				long_hold_done = 1'b1;
				stalling = 1'b1;
				hold_left = LONG_HOLD;
			end else if (hold_left > 0) begin
				hold_left--;
			end else if (stalling) begin
				stalling = 1'b0;
				hold_left = $urandom_range(0, 30);
			end else begin
				stalling = 1'b1;
				hold_left = pick_len() - 1;
			end
			out_stall <= stalling;
		end
	end

	initial begin
		logic [ADDR_W-1:0] pool [$];
		logic [ADDR_W-1:0] seen [$];
		logic [ADDR_W-1:0] a;
		logic [NQ_W-1:0] lims [9];
		int psz;
		int r;
		bit brisk;

		lims = '{5'd2, 5'd5, 5'd1, 5'd9, 5'd16, 5'd31, 5'd0, 5'd3, 5'd16};

		// directed: new entries, busy hit, frees, limit zero, drop, limit above max
		add_req(OP_PACKET, 32'h0000_0000, 0);
		add_req(OP_PACKET, 32'hFFFF_FFFF, 0);
		add_req(OP_PACKET, 32'h0000_0000, 0);
		add_req(OP_FREE,   32'hFFFF_FFFF, 0);
		add_req(OP_FREE,   32'h1234_5678, 1);
		add_req(OP_PACKET, 32'hAAAA_AAAA, 0);
		add_req(OP_PACKET, 32'h5555_5555, 0);
		add_cfg(5'd0);
		add_req(OP_PACKET, 32'h0A00_0001, 0);
		add_req(OP_PACKET, 32'h0A00_0002, 0);
		add_req(OP_FREE,   32'h0000_0000, 0);
		add_req(OP_FREE,   32'h0000_0000, 2);
		add_req(OP_PACKET, 32'h0A00_0002, 0);
		add_req(OP_PACKET, 32'h0000_0000, 0);
		add_cfg(5'd31);
		add_req(OP_PACKET, 32'h8000_0000, 0);
		add_req(OP_PACKET, 32'h0000_0001, 0);

		// random phases, each with its own limit and address pool
		foreach (lims[p]) begin
			add_cfg(p == 7 ? 5'($urandom_range(0, 31)) : lims[p]);
			brisk = ($urandom_range(0, 2) == 0);
			pool.delete();
			psz = $urandom_range(3, 24);
			for (int k = 0; k < psz; k++) begin
				if (seen.size() > 0 && $urandom_range(0, 2) == 0) begin
					pool = {pool, seen[$urandom_range(0, seen.size() - 1)]};
				end else begin
					a = $urandom;
					pool = {pool, a};
					seen = {seen, a};
				end
			end
			for (int k = 0; k < 84; k++) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					a = pool[$urandom_range(0, pool.size() - 1)];
				else if (r < 90)
					a = pool[$urandom_range(0, pool.size() - 1)];
				else
					a = $urandom;
				add_req((r >= 60 && r < 90) || r >= 95 ? OP_FREE : OP_PACKET, a,
					brisk ? 0 : pick_gap());
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_plan.size() != 0 || in_valid || expected_grants.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (err_cnt == 0)
			$display("destination_queue_assigner verification clean");
		else
			$display("destination_queue_assigner verification failed");
		$finish;
	end

	initial begin
		#1500000;
		$display("destination_queue_assigner verification failed");
		$finish;
	end

endmodule
